>>> design/bpme_pkg.sv
`timescale 1ns / 1ps

package bpme_pkg;

    // Word and field widths
    localparam int BYTE_W          = 8;
    localparam int BLOCK_W         = 24;
    localparam int BYTES_PER_BLOCK = 3;
    localparam int CODE_W          = 48;
    localparam int CFG_W           = 48;
    localparam int CFG_AW          = 1;

    // Register indexes on the config port
    localparam logic [CFG_AW-1:0] REG_MODULUS  = 1'b0;
    localparam logic [CFG_AW-1:0] REG_EXPONENT = 1'b1;

    // Block queue between packer and exponent engine (depth is a power of two)
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = 1;
    localparam int Q_CW    = 2;

    // Exponent engine sequencer
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_REDUCE,
        BK_SQUARE,
        BK_MULT,
        BK_DONE
    } bpme_bk_state_t;

    // Modular multiplier status
    typedef struct packed {
        logic busy;
        logic done;
    } bpme_mm_stat_t;

endpackage

>>> design/bpme_front.sv
`timescale 1ns / 1ps

// Byte packer: gathers up to three bytes little-endian into a block and
// pushes the block into the queue when it is full or closed by tlast.
module bpme_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [bpme_pkg::BYTE_W-1:0]  s_tdata,
    input  logic                         s_tlast,
    input  logic                         q_full,
    output logic                         q_push,
    output logic [bpme_pkg::BLOCK_W-1:0] q_block
);

    localparam logic [1:0] LastSlot = 2'(bpme_pkg::BYTES_PER_BLOCK - 1);

    logic [bpme_pkg::BLOCK_W-1:0] packed_reg, packed_next;
    logic [1:0]                   cnt_reg, cnt_next;
    logic [bpme_pkg::BLOCK_W-1:0] merged;
    logic                         accept;
    logic                         emit;

    // Hold off while the queue has no room for a block
    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    // Place the byte by its position in the block
    always_comb begin
        case (cnt_reg)
            2'd0:    merged = packed_reg | {16'd0, s_tdata};
            2'd1:    merged = packed_reg | {8'd0, s_tdata, 8'd0};
            default: merged = packed_reg | {s_tdata, 16'd0};
        endcase
    end

    assign emit    = accept && ((cnt_reg == LastSlot) || s_tlast);
    assign q_push  = emit;
    assign q_block = merged;

    always_comb begin
        packed_next = packed_reg;
        cnt_next    = cnt_reg;
        if (emit) begin
            packed_next = '0;
            cnt_next    = '0;
        end else if (accept) begin
            packed_next = merged;
            cnt_next    = cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            packed_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            packed_reg <= packed_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

>>> design/bpme_queue.sv
`timescale 1ns / 1ps

// Two-entry block queue between the packer and the exponent engine.
module bpme_queue (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         push,
    input  logic [bpme_pkg::BLOCK_W-1:0] push_block,
    input  logic                         pop,
    output logic [bpme_pkg::BLOCK_W-1:0] head_block,
    output logic                         full,
    output logic                         empty
);

    logic [bpme_pkg::BLOCK_W-1:0] slot_reg [bpme_pkg::Q_DEPTH];
    logic [bpme_pkg::Q_AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [bpme_pkg::Q_AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [bpme_pkg::Q_CW-1:0]    count_reg, count_next;

    assign full       = (count_reg == bpme_pkg::Q_CW'(bpme_pkg::Q_DEPTH));
    assign empty      = (count_reg == '0);
    assign head_block = slot_reg[rd_ptr_reg];

    // Pointer and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_block;
        end
    end

endmodule

>>> design/bpme_modmul.sv
`timescale 1ns / 1ps

// Bit-serial modular multiplier: result = (a * b) mod m, with a < m.
// Walks b from its top bit: each step doubles the partial result mod m
// and, for a set bit, adds a mod m in a second step.
module bpme_modmul #(
    parameter int W  = 48,
    parameter int BW = 48
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [W-1:0]           a,
    input  logic [BW-1:0]          b,
    input  logic [W-1:0]           m,
    output bpme_pkg::bpme_mm_stat_t stat,
    output logic [W-1:0]           result
);

    localparam int CW = $clog2(BW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic          phase_reg, phase_next;
    logic [W-1:0]  r_reg, r_next;
    logic [W-1:0]  a_reg, a_next;
    logic [BW-1:0] b_reg, b_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    logic [W:0]    dbl_raw, sum_raw, m_ext;
    logic [W-1:0]  dbl_red, sum_red;
    logic          step_end;

    // Double or add, each followed by one conditional subtract
    assign m_ext   = {1'b0, m};
    assign dbl_raw = {r_reg, 1'b0};
    assign sum_raw = {1'b0, r_reg} + {1'b0, a_reg};
    assign dbl_red = (dbl_raw >= m_ext) ? W'(dbl_raw - m_ext) : W'(dbl_raw);
    assign sum_red = (sum_raw >= m_ext) ? W'(sum_raw - m_ext) : W'(sum_raw);

    // A bit is finished after the add, or right after the double for a zero bit
    assign step_end = busy_reg && (phase_reg || !b_reg[BW-1]);

    always_comb begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        phase_next = phase_reg;
        r_next     = r_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        cnt_next   = cnt_reg;
        if (start) begin
            busy_next  = 1'b1;
            phase_next = 1'b0;
            r_next     = '0;
            a_next     = a;
            b_next     = b;
            cnt_next   = CW'(BW);
        end else if (busy_reg) begin
            if (phase_reg) begin
                r_next     = sum_red;
                phase_next = 1'b0;
            end else begin
                r_next     = dbl_red;
                phase_next = b_reg[BW-1];
            end
            if (step_end) begin
                b_next   = {b_reg[BW-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= 1'b0;
        end else begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        r_reg   <= r_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        cnt_reg <= cnt_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result    = r_reg;

endmodule

>>> design/bpme_back.sv
`timescale 1ns / 1ps

// Exponent engine: pops a block, reduces it mod n, then runs left-to-right
// square-and-multiply over all W exponent bits on the shared multiplier.
// The finished code sits in an output register until the sink takes it.
module bpme_back #(
    parameter int W  = 48,
    parameter int BW = 48
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         q_empty,
    input  logic [bpme_pkg::BLOCK_W-1:0] q_block,
    output logic                         q_pop,
    input  logic [W-1:0]                 modulus,
    input  logic [W-1:0]                 exponent,
    output logic                         mm_start,
    output logic [W-1:0]                 mm_a,
    output logic [BW-1:0]                mm_b,
    input  bpme_pkg::bpme_mm_stat_t      mm_stat,
    input  logic [W-1:0]                 mm_result,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [W-1:0]                 out_code
);

    localparam int IW = $clog2(W);

    bpme_pkg::bpme_bk_state_t state_reg, state_next;

    logic [W-1:0]  acc_reg, acc_next;
    logic [W-1:0]  base_reg, base_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic          out_valid_reg, out_valid_next;
    logic [W-1:0]  out_code_reg, out_code_next;
    logic          mod_small;
    logic          out_free;

    // Moduli of zero or one give a code of zero with no work
    assign mod_small = (modulus < W'(2));
    assign out_free  = !out_valid_reg || m_tready;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bpme_pkg::BK_IDLE: begin
                if (!q_empty) begin
                    state_next = mod_small ? bpme_pkg::BK_DONE : bpme_pkg::BK_REDUCE;
                end
            end
            bpme_pkg::BK_REDUCE: begin
                if (mm_stat.done) begin
                    state_next = bpme_pkg::BK_SQUARE;
                end
            end
            bpme_pkg::BK_SQUARE: begin
                if (mm_stat.done) begin
                    if (exponent[idx_reg]) begin
                        state_next = bpme_pkg::BK_MULT;
                    end else if (idx_reg == '0) begin
                        state_next = bpme_pkg::BK_DONE;
                    end
                end
            end
            bpme_pkg::BK_MULT: begin
                if (mm_stat.done) begin
                    state_next = (idx_reg == '0) ? bpme_pkg::BK_DONE
                                                 : bpme_pkg::BK_SQUARE;
                end
            end
            bpme_pkg::BK_DONE: begin
                if (out_free) begin
                    state_next = bpme_pkg::BK_IDLE;
                end
            end
            default: state_next = bpme_pkg::BK_IDLE;
        endcase
    end

    // Outputs and datapath updates
    always_comb begin
        q_pop          = 1'b0;
        mm_start       = 1'b0;
        mm_a           = acc_reg;
        mm_b           = BW'(acc_reg);
        acc_next       = acc_reg;
        base_next      = base_reg;
        idx_next       = idx_reg;
        out_code_next  = out_code_reg;
        out_valid_next = out_valid_reg && !m_tready;
        case (state_reg)
            bpme_pkg::BK_IDLE: begin
                if (!q_empty) begin
                    q_pop    = 1'b1;
                    acc_next = mod_small ? W'(0) : W'(1);
                    idx_next = IW'(W - 1);
                    // block mod n as 1 * block mod n
                    mm_start = !mod_small;
                    mm_a     = W'(1);
                    mm_b     = BW'(q_block);
                end
            end
            bpme_pkg::BK_REDUCE: begin
                if (mm_stat.done) begin
                    base_next = mm_result;
                    mm_start  = 1'b1;
                end
            end
            bpme_pkg::BK_SQUARE: begin
                if (mm_stat.done) begin
                    acc_next = mm_result;
                    mm_a     = mm_result;
                    if (exponent[idx_reg]) begin
                        mm_start = 1'b1;
                        mm_b     = BW'(base_reg);
                    end else if (idx_reg != '0) begin
                        mm_start = 1'b1;
                        mm_b     = BW'(mm_result);
                        idx_next = idx_reg - 1'b1;
                    end
                end
            end
            bpme_pkg::BK_MULT: begin
                if (mm_stat.done) begin
                    acc_next = mm_result;
                    mm_a     = mm_result;
                    mm_b     = BW'(mm_result);
                    if (idx_reg != '0) begin
                        mm_start = 1'b1;
                        idx_next = idx_reg - 1'b1;
                    end
                end
            end
            bpme_pkg::BK_DONE: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_code_next  = acc_reg;
                end
            end
            default: begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= bpme_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg      <= acc_next;
        base_reg     <= base_next;
        idx_reg      <= idx_next;
        out_code_reg <= out_code_next;
    end

    assign m_tvalid = out_valid_reg;
    assign out_code = out_code_reg;

endmodule

>>> design/byte_packing_modexp_encryptor_unit.sv
`timescale 1ns / 1ps

// Byte-packing modular exponentiation encryptor.
// Slave stream: one message byte per word in s_tdata, s_tlast on the last
// byte of a message. Every three bytes (first byte lowest) form a 24-bit
// block; tlast closes a shorter block with zero high bytes.
// Master stream: one word per block, m_tdata = block^exponent mod modulus.
// Config: cfg_we writes cfg_wdata to register cfg_addr (0 modulus, 1
// exponent); write only while no block is in flight. Reset: modulus 2,
// exponent 1, packer and queue empty, no word pending.
// Work: a block costs one modular product for the initial reduction, then
// MOD_BITS squarings plus one product per set exponent bit. Each product on
// the shared bit-serial multiplier walks B = max(MOD_BITS, 24) multiplier
// bits, with one more add step per set bit. Modulus below 2 gives code 0
// with no products.
// A two-block queue sits between packer and engine, so bytes keep flowing
// while a block is worked on; s_tready drops only when the queue is full.
// The result register holds while m_tready is low and the engine finishes
// the next block behind it, then waits.
module byte_packing_modexp_encryptor_unit #(
    parameter int MOD_BITS = 48
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [bpme_pkg::BYTE_W-1:0] s_tdata,    // [7:0] data_byte
    input  logic                        s_tlast,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [bpme_pkg::CODE_W-1:0] m_tdata,    // [47:0] code
    input  logic                        cfg_we,
    input  logic [bpme_pkg::CFG_AW-1:0] cfg_addr,
    input  logic [bpme_pkg::CFG_W-1:0]  cfg_wdata
);

    localparam int W     = MOD_BITS;
    localparam int BW    = (MOD_BITS > bpme_pkg::BLOCK_W) ? MOD_BITS : bpme_pkg::BLOCK_W;
    localparam int CodeW = bpme_pkg::CODE_W;

    logic [W-1:0]                 modulus_reg, modulus_next;
    logic [W-1:0]                 exponent_reg, exponent_next;

    logic                         q_push, q_pop, q_full, q_empty;
    logic [bpme_pkg::BLOCK_W-1:0] push_block, head_block;

    logic                         mm_start;
    logic [W-1:0]                 mm_a, mm_result;
    logic [BW-1:0]                mm_b;
    bpme_pkg::bpme_mm_stat_t      mm_stat;
    logic [W-1:0]                 out_code;

    // Config registers, low MOD_BITS bits kept
    always_comb begin
        modulus_next  = modulus_reg;
        exponent_next = exponent_reg;
        if (cfg_we) begin
            case (cfg_addr)
                bpme_pkg::REG_MODULUS:  modulus_next  = W'(cfg_wdata);
                bpme_pkg::REG_EXPONENT: exponent_next = W'(cfg_wdata);
                default:                modulus_next  = modulus_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg  <= W'(2);
            exponent_reg <= W'(1);
        end else begin
            modulus_reg  <= modulus_next;
            exponent_reg <= exponent_next;
        end
    end

    bpme_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_block  (push_block)
    );

    bpme_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_block (push_block),
        .pop        (q_pop),
        .head_block (head_block),
        .full       (q_full),
        .empty      (q_empty)
    );

    bpme_modmul #(
        .W  (W),
        .BW (BW)
    ) u_modmul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mm_start),
        .a       (mm_a),
        .b       (mm_b),
        .m       (modulus_reg),
        .stat    (mm_stat),
        .result  (mm_result)
    );

    bpme_back #(
        .W  (W),
        .BW (BW)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_empty   (q_empty),
        .q_block   (head_block),
        .q_pop     (q_pop),
        .modulus   (modulus_reg),
        .exponent  (exponent_reg),
        .mm_start  (mm_start),
        .mm_a      (mm_a),
        .mm_b      (mm_b),
        .mm_stat   (mm_stat),
        .mm_result (mm_result),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .out_code  (out_code)
    );

    assign m_tdata = CodeW'(out_code);

endmodule

>>> design/bpme_checker.sv
`timescale 1ns / 1ps

// Port-level checks on the encryptor.
module bpme_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [bpme_pkg::CODE_W-1:0] m_tdata
);

    // A stalled result word stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    // A stalled result word keeps its value
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("m_tdata changed while stalled");

    // Reset leaves no result pending
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // The queue fills only through an accepted byte
    a_ready_fall: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_tready) |-> $past(s_tvalid && s_tready))
        else $error("s_tready fell without an accepted word");

endmodule

bind byte_packing_modexp_encryptor_unit bpme_checker u_bpme_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
